// File: hdl/dashed_midpoint_circle_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dashed midpoint circle rasterizer
// Clocked concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef DASHED_MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH
`define DASHED_MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked assertion with a fixed failure message.
`define DMCR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("dmcr assertion failed");
// Clocked assertion with a caller-supplied failure message.
`define DMCR_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define DMCR_ASSERT(lbl, clk, rst_n, prop)
`define DMCR_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif

`endif

// File: hdl/dmcr_pkg.sv
// ----------------------------------------------------------------------------
// dmcr_pkg
// Shared types and constants of the dashed midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package dmcr_pkg;

	localparam int DMCR_COORD_BITS = 10;
	localparam int DMCR_DASH_BITS  = 8;
	localparam int PIX_BITS        = 12;
	localparam int DEC_BITS        = 16;
	localparam int DLEN_BITS       = 8;
	localparam int BEAT_BITS       = 3;

	localparam logic [DLEN_BITS-1:0] DLEN_RESET = DLEN_BITS'(2);
	localparam logic [BEAT_BITS-1:0] BEAT_LAST  = BEAT_BITS'(7);

	// decision constants of the midpoint recurrence
	localparam logic [DEC_BITS-1:0] DEC_INIT   = DEC_BITS'(3);
	localparam logic [DEC_BITS-1:0] DEC_INC_X  = DEC_BITS'(6);
	localparam logic [DEC_BITS-1:0] DEC_INC_XY = DEC_BITS'(10);

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REC_PIXELS,
		REC_GAP,
		REC_DONE
	} rec_kind_t;

	typedef struct packed {
		logic      load;
		rec_kind_t kind;
	} rec_ctl_t;

endpackage

// File: hdl/dmcr_if.sv
// ----------------------------------------------------------------------------
// Rasterizer channels
// Command channel (start / step) and pixel result channel, valid/ready.
// ----------------------------------------------------------------------------
interface dmcr_cmd_if
	import dmcr_pkg::*;
	#(parameter int COORD_BITS = DMCR_COORD_BITS) ();
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [COORD_BITS-1:0] center_x;
	logic [COORD_BITS-1:0] center_y;
	logic [COORD_BITS-1:0] radius;

	modport source (output valid, opcode, center_x, center_y, radius, input ready);
	modport sink (input valid, opcode, center_x, center_y, radius, output ready);
endinterface

interface dmcr_pix_if
	import dmcr_pkg::*;
	();
	logic                       valid;
	logic                       ready;
	logic signed [PIX_BITS-1:0] pixel_x;
	logic signed [PIX_BITS-1:0] pixel_y;
	logic                       pixel_valid;
	logic                       circle_done;
	logic                       last_of_run;

	modport source (output valid, pixel_x, pixel_y, pixel_valid, circle_done, last_of_run,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_valid, circle_done, last_of_run,
		output ready);
endinterface

// File: hdl/dmcr_step.sv
// ----------------------------------------------------------------------------
// dmcr_step
// One midpoint octant step, or the start of a circle, plus the dash filter, purely combinational.
// ----------------------------------------------------------------------------
module dmcr_step
	import dmcr_pkg::*;
	#(
	parameter int COORD_BITS = DMCR_COORD_BITS,
	parameter int DASH_BITS  = DMCR_DASH_BITS
) (
	input  logic                  opcode,
	input  logic [COORD_BITS-1:0] center_x,
	input  logic [COORD_BITS-1:0] center_y,
	input  logic [COORD_BITS-1:0] radius,
	input  logic [DLEN_BITS-1:0]  dash_length,
	input  logic [COORD_BITS-1:0] cur_x,
	input  logic [COORD_BITS-1:0] cur_y,
	input  logic [DEC_BITS-1:0]   cur_dec,
	input  logic [DASH_BITS-1:0]  cur_dash,
	input  logic [COORD_BITS-1:0] cur_cx,
	input  logic [COORD_BITS-1:0] cur_cy,
	input  logic                  cur_active,
	output logic [COORD_BITS-1:0] nxt_x,
	output logic [COORD_BITS-1:0] nxt_y,
	output logic [DEC_BITS-1:0]   nxt_dec,
	output logic [DASH_BITS-1:0]  nxt_dash,
	output logic [COORD_BITS-1:0] nxt_cx,
	output logic [COORD_BITS-1:0] nxt_cy,
	output logic                  nxt_active,
	output rec_kind_t             kind
);

	localparam int CMP_BITS = (DASH_BITS > DLEN_BITS) ? DASH_BITS : DLEN_BITS;

	logic [DEC_BITS-1:0]  dec_x;
	logic [DEC_BITS-1:0]  dec_y;
	logic [DEC_BITS-1:0]  dec_diff;
	logic [DASH_BITS-1:0] dash_base;
	logic                 point;

	assign dec_x    = DEC_BITS'(cur_x);
	assign dec_y    = DEC_BITS'(cur_y);
	assign dec_diff = dec_x - dec_y;

	always_comb begin
		nxt_x      = cur_x;
		nxt_y      = cur_y;
		nxt_dec    = cur_dec;
		nxt_cx     = cur_cx;
		nxt_cy     = cur_cy;
		nxt_active = cur_active;
		dash_base  = cur_dash;
		point      = 1'b0;
		if (opcode == OP_START) begin
			nxt_cx     = center_x;
			nxt_cy     = center_y;
			nxt_x      = '0;
			nxt_y      = radius;
			nxt_dec    = DEC_INIT - (DEC_BITS'(radius) << 1);
			nxt_active = 1'b1;
			dash_base  = '0;
			point      = 1'b1;
		end else if (!cur_active || (cur_x >= cur_y)) begin
			nxt_active = 1'b0;
		end else begin
			point = 1'b1;
			nxt_x = cur_x + COORD_BITS'(1);
			// decision <= 0: move east only, otherwise south-east
			if (cur_dec[DEC_BITS-1] || (cur_dec == '0)) begin
				nxt_dec = cur_dec + (dec_x << 2) + DEC_INC_X;
			end else begin
				nxt_dec = cur_dec + (dec_diff << 2) + DEC_INC_XY;
				nxt_y   = cur_y - COORD_BITS'(1);
			end
		end
	end

	always_comb begin
		nxt_dash = cur_dash;
		kind     = REC_DONE;
		if (point) begin
			if (CMP_BITS'(dash_base) < CMP_BITS'(dash_length)) begin
				kind     = REC_PIXELS;
				nxt_dash = dash_base + DASH_BITS'(1);
			end else begin
				kind     = REC_GAP;
				nxt_dash = '0;
			end
		end
	end

endmodule

// File: hdl/dmcr_emit.sv
// ----------------------------------------------------------------------------
// dmcr_emit
// Point record register and beat sequencer for the eight mirrored pixels.
// ----------------------------------------------------------------------------
`include "dashed_midpoint_circle_rasterizer_assert.svh"

module dmcr_emit
	import dmcr_pkg::*;
	#(
	parameter int COORD_BITS = DMCR_COORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rec_ctl_t              ctl,
	input  logic [COORD_BITS-1:0] rec_cx,
	input  logic [COORD_BITS-1:0] rec_cy,
	input  logic [COORD_BITS-1:0] rec_x,
	input  logic [COORD_BITS-1:0] rec_y,
	output logic                  free,
	dmcr_pix_if.source            pixel
);

	localparam int CALC_BITS = (COORD_BITS + 2 > PIX_BITS) ? COORD_BITS + 2 : PIX_BITS;

	rec_kind_t             kind_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic                  busy_q;
	logic [BEAT_BITS-1:0]  beat_q;

	logic                 taken;
	logic                 last_beat;
	logic                 swap;
	logic                 neg_x;
	logic                 neg_y;
	logic [CALC_BITS-1:0] off_x;
	logic [CALC_BITS-1:0] off_y;
	logic [CALC_BITS-1:0] base_x;
	logic [CALC_BITS-1:0] base_y;
	logic [CALC_BITS-1:0] sum_x;
	logic [CALC_BITS-1:0] sum_y;

	assign taken     = pixel.valid && pixel.ready;
	assign last_beat = (kind_q != REC_PIXELS) || (beat_q == BEAT_LAST);
	assign free      = !busy_q || (taken && last_beat);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kind_q <= ctl.kind;
			cx_q   <= rec_cx;
			cy_q   <= rec_cy;
			x_q    <= rec_x;
			y_q    <= rec_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= '0;
		end else if (ctl.load) begin
			busy_q <= 1'b1;
			beat_q <= '0;
		end else if (taken) begin
			if (last_beat) begin
				busy_q <= 1'b0;
			end else begin
				beat_q <= beat_q + BEAT_BITS'(1);
			end
		end
	end

	// beats 0..3 mirror (x, y), beats 4..7 mirror the swapped pair (y, x)
	assign swap   = beat_q[2];
	assign neg_x  = swap ? beat_q[1] : beat_q[0];
	assign neg_y  = swap ? beat_q[0] : beat_q[1];
	assign off_x  = CALC_BITS'(swap ? y_q : x_q);
	assign off_y  = CALC_BITS'(swap ? x_q : y_q);
	assign base_x = CALC_BITS'(cx_q);
	assign base_y = CALC_BITS'(cy_q);
	assign sum_x  = neg_x ? (base_x - off_x) : (base_x + off_x);
	assign sum_y  = neg_y ? (base_y - off_y) : (base_y + off_y);

	assign pixel.valid = busy_q;

	always_comb begin
		case (kind_q)
			REC_PIXELS: begin
				pixel.pixel_x     = sum_x[PIX_BITS-1:0];
				pixel.pixel_y     = sum_y[PIX_BITS-1:0];
				pixel.pixel_valid = 1'b1;
				pixel.circle_done = 1'b0;
				pixel.last_of_run = (beat_q == BEAT_LAST);
			end
			REC_DONE: begin
				pixel.pixel_x     = '0;
				pixel.pixel_y     = '0;
				pixel.pixel_valid = 1'b0;
				pixel.circle_done = 1'b1;
				pixel.last_of_run = 1'b1;
			end
			default: begin
				pixel.pixel_x     = '0;
				pixel.pixel_y     = '0;
				pixel.pixel_valid = 1'b0;
				pixel.circle_done = 1'b0;
				pixel.last_of_run = 1'b1;
			end
		endcase
	end

	`DMCR_ASSERT_MSG(a_load_when_free, clk, arst_n, ctl.load |-> free, "record overwritten")
	`DMCR_ASSERT(a_single_beat_idle, clk, arst_n,
		(busy_q && (kind_q != REC_PIXELS)) |-> (beat_q == '0))
	`DMCR_ASSERT(a_beat_advance, clk, arst_n,
		(taken && !last_beat && !ctl.load) |=>
		(busy_q && (beat_q == $past(beat_q) + BEAT_BITS'(1))))
	`DMCR_ASSERT_MSG(a_last_on_eighth, clk, arst_n,
		(pixel.valid && pixel.pixel_valid && pixel.last_of_run) |-> (beat_q == BEAT_LAST),
		"early last pixel")

endmodule

// File: hdl/dashed_midpoint_circle_rasterizer.sv
// Latency: the first result beat of an item is offered the cycle after the item is accepted.
// Output: a drawn point takes 8 output beats, a gap or a done report takes 1; the
//   single-entry point record sets the rate, and the next item is taken in the cycle
//   that the last beat of the current one leaves, so a stalled output also holds commands.
// Reset (arst_n low, asynchronous): no circle active, dash_length back to 2, channel idle.
// ----------------------------------------------------------------------------
// dashed_midpoint_circle_rasterizer
// Bresenham midpoint circle generator with a dash pattern over the octant points.
// ----------------------------------------------------------------------------
module dashed_midpoint_circle_rasterizer
	import dmcr_pkg::*;
	#(
	parameter int COORD_BITS = DMCR_COORD_BITS,
	parameter int DASH_BITS  = DMCR_DASH_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 dash_length_we,
	input  logic [DLEN_BITS-1:0] dash_length_wdata,
	dmcr_cmd_if.sink             cmd,
	dmcr_pix_if.source           pixel
);

	// octant walk state
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic [DEC_BITS-1:0]   dec_q;
	logic [DASH_BITS-1:0]  dash_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic                  active_q;
	logic [DLEN_BITS-1:0]  dash_length_q;

	// next state from the step unit
	logic [COORD_BITS-1:0] nxt_x;
	logic [COORD_BITS-1:0] nxt_y;
	logic [DEC_BITS-1:0]   nxt_dec;
	logic [DASH_BITS-1:0]  nxt_dash;
	logic [COORD_BITS-1:0] nxt_cx;
	logic [COORD_BITS-1:0] nxt_cy;
	logic                  nxt_active;
	rec_kind_t             kind;

	logic     accept;
	logic     free;
	rec_ctl_t ctl;

	// Take a new command beat whenever the point record is empty or drains this cycle.
	assign cmd.ready = free;
	assign accept    = cmd.valid && cmd.ready;

	// Configuration register: write only while idle (the block does not enforce this), no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_length_q <= DLEN_RESET;
		end else if (dash_length_we) begin
			dash_length_q <= dash_length_wdata;
		end
	end

	// One step of the midpoint recurrence plus the dash filter.
	dmcr_step #(
		.COORD_BITS (COORD_BITS),
		.DASH_BITS  (DASH_BITS)
	) u_step (
		.opcode      (cmd.opcode),
		.center_x    (cmd.center_x),
		.center_y    (cmd.center_y),
		.radius      (cmd.radius),
		.dash_length (dash_length_q),
		.cur_x       (x_q),
		.cur_y       (y_q),
		.cur_dec     (dec_q),
		.cur_dash    (dash_q),
		.cur_cx      (cx_q),
		.cur_cy      (cy_q),
		.cur_active  (active_q),
		.nxt_x       (nxt_x),
		.nxt_y       (nxt_y),
		.nxt_dec     (nxt_dec),
		.nxt_dash    (nxt_dash),
		.nxt_cx      (nxt_cx),
		.nxt_cy      (nxt_cy),
		.nxt_active  (nxt_active),
		.kind        (kind)
	);

	// Commit the walk state on every accepted command beat; hold otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			dec_q    <= '0;
			dash_q   <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			x_q      <= nxt_x;
			y_q      <= nxt_y;
			dec_q    <= nxt_dec;
			dash_q   <= nxt_dash;
			cx_q     <= nxt_cx;
			cy_q     <= nxt_cy;
			active_q <= nxt_active;
		end
	end

	// Load the point record with the updated position; the emitter fans it out.
	assign ctl.load = accept;
	assign ctl.kind = kind;

	dmcr_emit #(
		.COORD_BITS (COORD_BITS)
	) u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rec_cx (nxt_cx),
		.rec_cy (nxt_cy),
		.rec_x  (nxt_x),
		.rec_y  (nxt_y),
		.free   (free),
		.pixel  (pixel)
	);

endmodule
